// File: rtl/dcsb_pkg.sv
// ----------------------------------------------------------------------------
// dcsb_pkg
// Shared types and constants of the draw command sort and batch block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsb_pkg;

  // fixed field widths
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned GSIZE_W = 7;
  localparam int unsigned KEY_W   = 33;

  // one incoming draw command request
  typedef struct packed {
    logic [31:0]        num_indices;
    logic [31:0]        first_index;
    logic signed [31:0] vertex_offset;
    logic [9:0]         instance_id;
    logic [31:0]        material_key;
    logic               skinned;
    logic               last;
  } cmd_t;

  // one sorted result
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        out_num_indices;
    logic [31:0]        out_first_index;
    logic signed [31:0] out_vertex_offset;
    logic [9:0]         out_instance_id;
    logic [31:0]        out_material_key;
    logic               out_skinned;
    logic               group_start;
    logic [GSIZE_W-1:0] group_size;
    logic               overflow;
    logic               last_out;
  } res_t;

  // one stored command; the sort key sits on top
  typedef struct packed {
    logic [31:0]        material_key;
    logic               skinned;
    logic [31:0]        num_indices;
    logic [31:0]        first_index;
    logic signed [31:0] vertex_offset;
    logic [9:0]         instance_id;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_SCAN_END,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/draw_command_sort_and_batch_core.sv
// ----------------------------------------------------------------------------
// draw_command_sort_and_batch_core
// Collects a frame of draw commands into a RAM kept sorted by
// (material_key, skinned) with stable order, then streams them out with
// run-length grouping on the command marked last.
// ----------------------------------------------------------------------------
//
//  channel   signals                 direction  handshake
//  --------  ----------------------  ---------  ------------------------------
//  command   start, busy, cmd_i      in         taken when start && !busy
//  result    res_valid_o, res_o      out        one-cycle strobe, no stall
//
//  A command into an empty store is written straight into slot 0; otherwise
//  the stored entries with a larger key are moved up one slot (one per cycle,
//  one RAM read and one RAM write per cycle) before the new entry is written.
//  On the last command, a grouping scan over the N stored commands and the
//  result stream follow; results then leave one per cycle.
//  Reset clears the fill count and drop flag; RAM contents need no clearing.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
`default_nettype none

module draw_command_sort_and_batch_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire dcsb_pkg::cmd_t cmd_i,
  output logic                res_valid_o,
  output dcsb_pkg::res_t      res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(dcsb_pkg::entry_t);

  // registers
  dcsb_pkg::state_e state_q, state_d;
  dcsb_pkg::cmd_t   cmd_q, cmd_d;
  logic [CW-1:0]    count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [dcsb_pkg::KEY_W-1:0] prev_key_q, prev_key_d;
  logic [AW-1:0]    run_start_q, run_start_d;
  logic [CW-1:0]    run_len_q, run_len_d;
  dcsb_pkg::res_t   res_q, res_d;
  logic             res_valid_q, res_valid_d;

  // RAM ports
  logic             ent_we;
  logic [AW-1:0]    ent_waddr;
  dcsb_pkg::entry_t ent_wdata;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    ent_rdata;
  logic             gs_we;
  logic [AW-1:0]    gs_waddr;
  logic [CW-1:0]    gs_wdata;
  logic [CW-1:0]    gs_rdata;

  // decoded helpers
  dcsb_pkg::entry_t in_ent, held_ent, rd_ent;
  logic [dcsb_pkg::KEY_W-1:0] rd_key, new_key;
  logic             accept;
  logic             has_room;
  logic             idx_is_end;
  logic             shift_more;
  logic             run_break;
  logic [CW-1:0]    count_m1;

  assign busy        = (state_q != dcsb_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign has_room    = (count_q < CW'(CAPACITY));
  assign count_m1    = count_q - CW'(1);
  assign rd_ent      = dcsb_pkg::entry_t'(ent_rdata);
  assign rd_key      = {rd_ent.material_key, rd_ent.skinned};
  assign new_key     = {cmd_q.material_key, cmd_q.skinned};
  assign idx_is_end  = ((CW'(idx_q) + CW'(1)) == count_q);
  assign shift_more  = (rd_key > new_key);
  assign run_break   = (idx_q == '0) || (rd_key != prev_key_q);

  // pack commands into store entries
  always_comb begin
    in_ent.material_key  = cmd_i.material_key;
    in_ent.skinned       = cmd_i.skinned;
    in_ent.num_indices   = cmd_i.num_indices;
    in_ent.first_index   = cmd_i.first_index;
    in_ent.vertex_offset = cmd_i.vertex_offset;
    in_ent.instance_id   = cmd_i.instance_id;
    held_ent.material_key  = cmd_q.material_key;
    held_ent.skinned       = cmd_q.skinned;
    held_ent.num_indices   = cmd_q.num_indices;
    held_ent.first_index   = cmd_q.first_index;
    held_ent.vertex_offset = cmd_q.vertex_offset;
    held_ent.instance_id   = cmd_q.instance_id;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcsb_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_room && (count_q != '0)) begin
            state_d = dcsb_pkg::ST_SHIFT;
          end else if (cmd_i.last) begin
            state_d = dcsb_pkg::ST_SCAN_RD;
          end
        end
      end
      dcsb_pkg::ST_SHIFT: begin
        if (shift_more) begin
          if (ptr_q == AW'(1)) begin
            state_d = dcsb_pkg::ST_PLACE;
          end
        end else begin
          state_d = cmd_q.last ? dcsb_pkg::ST_SCAN_RD : dcsb_pkg::ST_IDLE;
        end
      end
      dcsb_pkg::ST_PLACE: begin
        state_d = cmd_q.last ? dcsb_pkg::ST_SCAN_RD : dcsb_pkg::ST_IDLE;
      end
      dcsb_pkg::ST_SCAN_RD: begin
        state_d = dcsb_pkg::ST_SCAN;
      end
      dcsb_pkg::ST_SCAN: begin
        if (idx_is_end) begin
          state_d = dcsb_pkg::ST_SCAN_END;
        end
      end
      dcsb_pkg::ST_SCAN_END: begin
        state_d = dcsb_pkg::ST_EMIT_RD;
      end
      dcsb_pkg::ST_EMIT_RD: begin
        state_d = dcsb_pkg::ST_EMIT;
      end
      dcsb_pkg::ST_EMIT: begin
        if (idx_is_end) begin
          state_d = dcsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcsb_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cmd_d       = cmd_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    prev_key_d  = prev_key_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ent_we      = 1'b0;
    ent_waddr   = ptr_q;
    ent_wdata   = held_ent;
    rd_addr     = idx_q + AW'(1);
    gs_we       = 1'b0;
    gs_waddr    = run_start_q;
    gs_wdata    = run_len_q;

    case (state_q)
      // take a request; empty store writes slot 0 at once, a full store drops it
      dcsb_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          if (has_room) begin
            if (count_q == '0) begin
              ent_we    = 1'b1;
              ent_waddr = '0;
              ent_wdata = in_ent;
              count_d   = count_q + CW'(1);
            end else begin
              rd_addr = count_m1[AW-1:0];
              ptr_d   = count_q[AW-1:0];
            end
          end else begin
            dropped_d = 1'b1;
          end
        end
      end
      // move a larger neighbor up, or drop the new entry in its slot
      dcsb_pkg::ST_SHIFT: begin
        ent_we = 1'b1;
        if (shift_more) begin
          ent_wdata = rd_ent;
          ptr_d     = ptr_q - AW'(1);
          rd_addr   = ptr_q - AW'(2);
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      dcsb_pkg::ST_PLACE: begin
        ent_we  = 1'b1;
        count_d = count_q + CW'(1);
      end
      dcsb_pkg::ST_SCAN_RD: begin
        rd_addr = '0;
        idx_d   = '0;
      end
      // measure runs of equal keys, store each length at its first slot
      dcsb_pkg::ST_SCAN: begin
        idx_d      = idx_q + AW'(1);
        prev_key_d = rd_key;
        if (run_break) begin
          gs_we       = (idx_q != '0);
          run_start_d = idx_q;
          run_len_d   = CW'(1);
        end else begin
          run_len_d = run_len_q + CW'(1);
        end
      end
      dcsb_pkg::ST_SCAN_END: begin
        gs_we = 1'b1;
      end
      dcsb_pkg::ST_EMIT_RD: begin
        rd_addr = '0;
        idx_d   = '0;
      end
      // stream the sorted store out
      dcsb_pkg::ST_EMIT: begin
        idx_d                   = idx_q + AW'(1);
        prev_key_d              = rd_key;
        res_valid_d             = 1'b1;
        res_d.slot              = dcsb_pkg::SLOT_W'(idx_q);
        res_d.out_num_indices   = rd_ent.num_indices;
        res_d.out_first_index   = rd_ent.first_index;
        res_d.out_vertex_offset = rd_ent.vertex_offset;
        res_d.out_instance_id   = rd_ent.instance_id;
        res_d.out_material_key  = rd_ent.material_key;
        res_d.out_skinned       = rd_ent.skinned;
        res_d.group_start       = run_break;
        res_d.group_size        = run_break ? dcsb_pkg::GSIZE_W'(gs_rdata) : '0;
        res_d.overflow          = dropped_q;
        res_d.last_out          = idx_is_end;
        if (idx_is_end) begin
          count_d   = '0;
          dropped_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcsb_pkg::ST_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ptr_q       <= ptr_d;
    idx_q       <= idx_d;
    prev_key_q  <= prev_key_d;
    run_start_q <= run_start_d;
    run_len_q   <= run_len_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // sorted command store
  dcsb_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ent_rdata)
  );

  // run length per group start
  dcsb_ram #(
    .WIDTH (CW),
    .DEPTH (CAPACITY)
  ) u_gsize_ram (
    .clk_i   (clk_i),
    .we_i    (gs_we),
    .waddr_i (gs_waddr),
    .wdata_i (gs_wdata),
    .raddr_i (rd_addr),
    .rdata_o (gs_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/dcsb_ram.sv
// ----------------------------------------------------------------------------
// dcsb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/dcsb_checker.sv
// ----------------------------------------------------------------------------
// dcsb_checker
// Port-level checks on the result stream of the sort and batch core.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsb_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           busy,
  input wire logic           res_valid_o,
  input wire dcsb_pkg::res_t res_o
);

  // group size only on a group's first command
  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.group_start |-> res_o.group_size == '0)
    else $error("group_size set on a non-start command");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.group_start |-> res_o.group_size != '0)
    else $error("empty group at group start");

  // a frame streams without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_out |=> res_valid_o)
    else $error("gap inside result burst");

  // slots count up within a frame
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o) && !$past(res_o.last_out)
    |-> res_o.slot == dcsb_pkg::SLOT_W'($past(res_o.slot) + 1'b1))
    else $error("slot did not advance by one");

  // mid-frame the core refuses new requests
  a_busy_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_out |-> busy)
    else $error("core idle during result burst");

endmodule

bind draw_command_sort_and_batch_core dcsb_checker u_dcsb_checker (.*);

`default_nettype wire
